>>> hw/rtl/bresenham_line_rasterizer_macros.svh
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/brl_pkg.sv
`default_nettype none

package brl_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIM_BITS   = 12;
  localparam int COLOR_BITS = 32;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 3;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  command;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    logic [COLOR_BITS-1:0] pixel_color;
  } brl_in_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic                  inside_res;
    logic [COLOR_BITS-1:0] color_out;
    logic                  last;
  } brl_out_t;

  typedef struct packed {
    logic                  command;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    logic [COLOR_BITS-1:0] pixel_color;
    logic [COORD_BITS-1:0] delta_x;
    logic [COORD_BITS-1:0] delta_y;
    logic                  step_x_negative;
    logic                  step_y_negative;
  } brl_pre_t;

  typedef struct packed {
    coord_t                cur_x;
    coord_t                cur_y;
    coord_t                end_x;
    coord_t                end_y;
    logic [COORD_BITS-1:0] delta_x;
    logic [COORD_BITS-1:0] delta_y;
    logic                  step_x_negative;
    logic                  step_y_negative;
    logic signed [ERR_BITS-1:0] error_term;
    logic [COLOR_BITS-1:0] line_color;
    logic                  active;
  } brl_line_t;

endpackage

`default_nettype wire

>>> hw/rtl/brl_step.sv
`default_nettype none

module brl_step (
  input  brl_pkg::brl_pre_t                 pre_i,
  input  brl_pkg::brl_line_t                line_i,
  input  logic [brl_pkg::DIM_BITS-1:0]      width_i,
  input  logic [brl_pkg::DIM_BITS-1:0]      height_i,
  output brl_pkg::brl_line_t                line_o,
  output brl_pkg::brl_out_t                 pix_o,
  output logic                              emit_o
);

  localparam int CB   = brl_pkg::COORD_BITS;
  localparam int EB   = brl_pkg::ERR_BITS;
  localparam int EXT  = EB - CB;
  localparam int CMPB = (brl_pkg::COORD_BITS > brl_pkg::DIM_BITS) ?
                        brl_pkg::COORD_BITS : brl_pkg::DIM_BITS;

  logic signed [EB-1:0] dx_e;
  logic signed [EB-1:0] dy_e;
  logic signed [EB-1:0] sdx_e;
  logic signed [EB-1:0] sdy_e;
  logic signed [EB-1:0] err_adv;
  logic signed [EB:0]   e2;
  logic signed [EB:0]   dx_w;
  logic signed [EB:0]   ndy_w;
  logic                 step_x;
  logic                 step_y;
  logic                 done;
  logic                 in_x;
  logic                 in_y;

  assign dx_e  = $signed({{EXT{1'b0}}, line_i.delta_x});
  assign dy_e  = $signed({{EXT{1'b0}}, line_i.delta_y});
  assign sdx_e = $signed({{EXT{1'b0}}, pre_i.delta_x});
  assign sdy_e = $signed({{EXT{1'b0}}, pre_i.delta_y});

  assign e2    = $signed({line_i.error_term, 1'b0});
  assign dx_w  = $signed({dx_e[EB-1], dx_e});
  assign ndy_w = $signed((EB+1)'(0) - {dy_e[EB-1], dy_e});

  assign step_x = e2 > ndy_w;
  assign step_y = e2 < dx_w;

  assign err_adv = line_i.error_term - (step_x ? dy_e : EB'(0)) + (step_y ? dx_e : EB'(0));

  always_comb begin
    line_o = line_i;
    emit_o = 1'b0;
    if (pre_i.command == brl_pkg::CMD_START) begin
      line_o.cur_x           = pre_i.x_start;
      line_o.cur_y           = pre_i.y_start;
      line_o.end_x           = pre_i.x_end;
      line_o.end_y           = pre_i.y_end;
      line_o.delta_x         = pre_i.delta_x;
      line_o.delta_y         = pre_i.delta_y;
      line_o.step_x_negative = pre_i.step_x_negative;
      line_o.step_y_negative = pre_i.step_y_negative;
      line_o.error_term      = sdx_e - sdy_e;
      line_o.line_color      = pre_i.pixel_color;
      emit_o                 = 1'b1;
    end else if (line_i.active) begin
      line_o.error_term = err_adv;
      if (step_x) begin
        line_o.cur_x = line_i.step_x_negative ? line_i.cur_x - 1'b1 : line_i.cur_x + 1'b1;
      end
      if (step_y) begin
        line_o.cur_y = line_i.step_y_negative ? line_i.cur_y - 1'b1 : line_i.cur_y + 1'b1;
      end
      emit_o = 1'b1;
    end
    done = (line_o.cur_x == line_o.end_x) && (line_o.cur_y == line_o.end_y);
    if (emit_o) begin
      line_o.active = !done;
    end
  end

  assign in_x = !line_o.cur_x[CB-1] &&
                (CMPB'($unsigned(line_o.cur_x)) < CMPB'(width_i));
  assign in_y = !line_o.cur_y[CB-1] &&
                (CMPB'($unsigned(line_o.cur_y)) < CMPB'(height_i));

  always_comb begin
    pix_o.pixel_x    = line_o.cur_x;
    pix_o.pixel_y    = line_o.cur_y;
    pix_o.inside_res = in_x && in_y;
    pix_o.color_out  = line_o.line_color;
    pix_o.last       = done;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: a start transfer loads two signed endpoints and a color and
// returns the first pixel; each advance transfer returns the next pixel, flagged inside
// when it lies on the configured screen and last at the second endpoint. An advance with
// no line in progress returns nothing. One transfer is taken every clock unless in_stall
// is high; its result passes the input register and then the output register. The deltas
// and step signs are formed ahead of the input register; the error-term update, pixel
// step and clipping test then sit in one stage between the input and output registers,
// which sets the one-pixel-per-clock rate while out_stall is low. Screen width and height
// live at byte addresses 0 and 4 of the register port and reset to 640 and 480.
`default_nettype none

`include "bresenham_line_rasterizer_macros.svh"

module bresenham_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brl_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [brl_pkg::DATA_BITS-1:0]  pwdata,
  output logic [brl_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  brl_pkg::brl_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output brl_pkg::brl_out_t              out_data
);

  localparam int CB = brl_pkg::COORD_BITS;
  localparam int DB = brl_pkg::DIM_BITS;

  logic [DB-1:0]          width_r;
  logic [DB-1:0]          height_r;
  logic                   pipe_valid_r;
  brl_pkg::brl_pre_t      pipe_r;
  brl_pkg::brl_pre_t      pre_nxt;
  brl_pkg::brl_line_t     line_r;
  brl_pkg::brl_line_t     line_nxt;
  brl_pkg::brl_out_t      pix_nxt;
  logic                   emit_nxt;
  logic                   out_valid_r;
  brl_pkg::brl_out_t      out_data_r;
  logic                   adv2;
  logic                   take2;
  logic                   cfg_wr;
  logic signed [CB:0]     dxf;
  logic signed [CB:0]     dxb;
  logic signed [CB:0]     dyf;
  logic signed [CB:0]     dyb;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      brl_pkg::REG_SCREEN_WIDTH:  prdata = brl_pkg::DATA_BITS'(width_r);
      brl_pkg::REG_SCREEN_HEIGHT: prdata = brl_pkg::DATA_BITS'(height_r);
      default:                    prdata = '0;
    endcase
  end

  assign dxf = $signed({in_data.x_end[CB-1], in_data.x_end})
             - $signed({in_data.x_start[CB-1], in_data.x_start});
  assign dxb = $signed({in_data.x_start[CB-1], in_data.x_start})
             - $signed({in_data.x_end[CB-1], in_data.x_end});
  assign dyf = $signed({in_data.y_end[CB-1], in_data.y_end})
             - $signed({in_data.y_start[CB-1], in_data.y_start});
  assign dyb = $signed({in_data.y_start[CB-1], in_data.y_start})
             - $signed({in_data.y_end[CB-1], in_data.y_end});

  always_comb begin
    pre_nxt.command         = in_data.command;
    pre_nxt.x_start         = in_data.x_start;
    pre_nxt.y_start         = in_data.y_start;
    pre_nxt.x_end           = in_data.x_end;
    pre_nxt.y_end           = in_data.y_end;
    pre_nxt.pixel_color     = in_data.pixel_color;
    pre_nxt.delta_x         = dxf[CB] ? dxb[CB-1:0] : dxf[CB-1:0];
    pre_nxt.delta_y         = dyf[CB] ? dyb[CB-1:0] : dyf[CB-1:0];
    pre_nxt.step_x_negative = dxf[CB] || (dxf == '0);
    pre_nxt.step_y_negative = dyf[CB] || (dyf == '0);
  end

  assign adv2     = !out_valid_r || !out_stall;
  assign take2    = pipe_valid_r && adv2;
  assign in_stall = pipe_valid_r && !adv2;

  brl_step u_step (
    .pre_i    (pipe_r),
    .line_i   (line_r),
    .width_i  (width_r),
    .height_i (height_r),
    .line_o   (line_nxt),
    .pix_o    (pix_nxt),
    .emit_o   (emit_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= brl_pkg::WIDTH_RESET;
      height_r     <= brl_pkg::HEIGHT_RESET;
      pipe_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      line_r       <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          brl_pkg::REG_SCREEN_WIDTH:  width_r  <= pwdata[DB-1:0];
          brl_pkg::REG_SCREEN_HEIGHT: height_r <= pwdata[DB-1:0];
          default: ;
        endcase
      end
      if (!in_stall) begin
        pipe_valid_r <= in_valid;
      end
      if (adv2) begin
        out_valid_r <= take2 && emit_nxt;
      end
      if (take2) begin
        line_r <= line_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pipe_r <= pre_nxt;
    end
    if (take2 && emit_nxt) begin
      out_data_r <= pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BRL_ASSERT_NEXT(a_idle_advance_drop,
    take2 && (pipe_r.command == brl_pkg::CMD_ADVANCE) && !line_r.active, !out_valid_r,
    "advance with no line in progress produced a pixel")
  `BRL_ASSERT_NEXT(a_start_emits,
    take2 && (pipe_r.command == brl_pkg::CMD_START), out_valid_r,
    "start transfer produced no pixel")
  `BRL_ASSERT_NOW(a_last_idle, out_valid_r && out_data_r.last, !line_r.active,
    "line still active after its last pixel")
  `BRL_ASSERT_NOW(a_last_at_end, out_valid_r && out_data_r.last,
    (out_data_r.pixel_x == line_r.end_x) && (out_data_r.pixel_y == line_r.end_y),
    "last pixel is not the endpoint")
  `BRL_ASSERT_NOW(a_stall_full, in_stall, pipe_valid_r && out_valid_r,
    "input stalled with room in the pipeline")

endmodule

`default_nettype wire
